// File: sv/csr_sparse_matrix_vector_multiply_macros.svh
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// checked only while out of reset
`define CSRSPMV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define CSRSPMV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: sv/csrspmv_pkg.sv
`default_nettype none

package csrspmv_pkg;

    localparam int unsigned VECTOR_DEPTH_DEF = 1024;

    localparam int COL_W       = 10;
    localparam int VALUE_W     = 32;
    localparam int ROW_W       = 16;
    localparam int SUM_W       = 64;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 80;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ENTRY = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    // control of the item leaving the product stage
    typedef struct packed {
        logic valid;
        logic empty;
        logic last;
    } item_ctl_t;

    // column reduced into the store range by constant shift and subtract
    function automatic logic [COL_W-1:0] col_mod(input logic [COL_W-1:0] col,
                                                 input int unsigned depth);
        logic [COL_W-1:0]  r;
        logic [COL_W+16:0] step;
        r = col;
        for (int k = COL_W - 1; k >= 0; k--) begin
            step = (COL_W + 17)'(depth) << k;
            if (step <= (COL_W + 17)'(r)) begin
                r = r - COL_W'(step);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/csr_sparse_matrix_vector_multiply.sv
// Sparse matrix times dense vector in compressed-row order.
// Input channel s_*: one item per handshake. op load writes value into the
// vector store at column; op entry multiplies value by the stored element
// of column and adds it to the row sum; op empty reports a zero row.
// tlast on an entry closes the row and reports its sum.
// Result channel m_*: row index and Q32.32 saturated sum in tdata, the
// clip flag in tuser. Entries and empty rows pass a vector read stage,
// a product stage and the result register. Loads give no result.
// Throughput is one item per cycle unless a held result backs up the
// stages, set by the accumulate loop and the one read and one write
// port of the vector store.
// cfg_wr_en / cfg_wr_data set the row count at which the row index wraps;
// write it only while the block is idle.
// Reset clears the row sum, clip flag, row index and result valid and sets
// the row count to one; the vector store keeps its contents and must be
// loaded before it is read. When m_tready is low the result is held and
// the stages keep filling; s_tready falls only once every stage holds an
// item that cannot move on.
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
    parameter int unsigned VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [csrspmv_pkg::ROW_W-1:0]         cfg_wr_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // op [1:0], column [11:2], value [43:12], zero [47:44]
    input  wire logic [csrspmv_pkg::IN_TDATA_W-1:0]    s_tdata,
    // last_in_row
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // row_index [15:0], row_sum [79:16]
    output logic [csrspmv_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // saturated
    output logic                                       m_tuser
);
    import csrspmv_pkg::*;

    localparam int unsigned AW = $clog2(VECTOR_DEPTH);

    logic [ROW_W-1:0] row_count_reg;

    logic [1:0]                s_op;
    logic [COL_W-1:0]          s_column;
    logic signed [VALUE_W-1:0] s_value;
    logic [AW-1:0]             addr;
    logic                      accept;
    logic                      store_wr;
    logic                      row_item;

    logic                      s1_en, s2_en;
    logic                      s1_valid_reg, s1_empty_reg, s1_last_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic [VALUE_W-1:0]        s1_vec;
    logic signed [SUM_W-1:0]   s1_prod;

    logic                      s2_valid_reg, s2_empty_reg, s2_last_reg;
    logic signed [SUM_W-1:0]   s2_prod_reg;

    item_ctl_t                 s2_ctl;
    logic                      take;
    logic [ROW_W-1:0]          out_row;
    logic [SUM_W-1:0]          out_sum;

    assign s_op     = s_tdata[1:0];
    assign s_column = s_tdata[COL_W+1:2];
    assign s_value  = s_tdata[VALUE_W+COL_W+1:COL_W+2];
    assign addr     = AW'(col_mod(s_column, VECTOR_DEPTH));

    // a stage loads when it is empty or its item moves on
    assign s2_en    = !s2_valid_reg || take;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;
    assign accept   = s_tvalid && s1_en;
    assign store_wr = accept && (s_op == OP_LOAD);
    assign row_item = (s_op == OP_ENTRY) || (s_op == OP_EMPTY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_W'(1);
        end else if (cfg_wr_en) begin
            row_count_reg <= cfg_wr_data;
        end
    end

    csrspmv_vec_store #(
        .DEPTH (VECTOR_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (addr),
        .wr_data (s_value),
        .rd_en   (s1_en),
        .rd_addr (addr),
        .rd_data (s1_vec)
    );

    // loads and unused codes end at the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= accept && row_item;
            end
            if (s2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign s1_prod = s1_value_reg * $signed(s1_vec);

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_empty_reg <= (s_op == OP_EMPTY);
            s1_last_reg  <= s_tlast;
            s1_value_reg <= s_value;
        end
        if (s2_en) begin
            s2_empty_reg <= s1_empty_reg;
            s2_last_reg  <= s1_last_reg;
            s2_prod_reg  <= s1_prod;
        end
    end

    assign s2_ctl = '{valid: s2_valid_reg, empty: s2_empty_reg, last: s2_last_reg};

    csrspmv_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row_count (row_count_reg),
        .item      (s2_ctl),
        .product   (s2_prod_reg),
        .take      (take),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_row   (out_row),
        .out_sum   (out_sum),
        .out_sat   (m_tuser)
    );

    assign m_tdata = {out_sum, out_row};

endmodule

`default_nettype wire

// File: sv/csrspmv_vec_store.sv
`default_nettype none

module csrspmv_vec_store #(
    parameter int unsigned DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                              aclk,
    input  wire logic                              wr_en,
    input  wire logic [AW-1:0]                     wr_addr,
    input  wire logic [csrspmv_pkg::VALUE_W-1:0]   wr_data,
    input  wire logic                              rd_en,
    input  wire logic [AW-1:0]                     rd_addr,
    output logic      [csrspmv_pkg::VALUE_W-1:0]   rd_data
);
    import csrspmv_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/csrspmv_acc.sv
`default_nettype none

module csrspmv_acc (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [csrspmv_pkg::ROW_W-1:0]        row_count,
    input  wire csrspmv_pkg::item_ctl_t               item,
    input  wire logic signed [csrspmv_pkg::SUM_W-1:0] product,
    output logic                                      take,
    input  wire logic                                 out_ready,
    output logic                                      out_valid,
    output logic [csrspmv_pkg::ROW_W-1:0]             out_row,
    output logic [csrspmv_pkg::SUM_W-1:0]             out_sum,
    output logic                                      out_sat
);
    import csrspmv_pkg::*;

    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             clip_reg, clip_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             out_valid_reg, out_valid_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [SUM_W-1:0] out_sum_reg, out_sum_next;
    logic             out_sat_reg, out_sat_next;

    logic [SUM_W-1:0] sum;
    logic             ovf;
    logic [SUM_W-1:0] acc_add;
    logic             clip_add;
    logic [ROW_W:0]   row_inc;
    logic [ROW_W-1:0] row_adv;
    logic             emit;
    logic             out_free;

    always_comb begin
        sum      = acc_reg + SUM_W'(product);
        ovf      = (acc_reg[SUM_W-1] == product[SUM_W-1]) &&
                   (sum[SUM_W-1] != acc_reg[SUM_W-1]);
        // clip towards the sign of both operands
        acc_add  = ovf ? {acc_reg[SUM_W-1], {(SUM_W-1){~acc_reg[SUM_W-1]}}} : sum;
        clip_add = clip_reg | ovf;

        row_inc  = {1'b0, row_reg} + (ROW_W + 1)'(1);
        row_adv  = (row_inc >= {1'b0, row_count}) ? '0 : row_inc[ROW_W-1:0];

        emit     = item.valid && (item.empty || item.last);
        out_free = !out_valid_reg || out_ready;
        take     = item.valid && (!emit || out_free);

        acc_next       = acc_reg;
        clip_next      = clip_reg;
        row_next       = row_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_row_next   = out_row_reg;
        out_sum_next   = out_sum_reg;
        out_sat_next   = out_sat_reg;

        if (take) begin
            if (item.empty) begin
                // partial sum of an open row is kept
                out_valid_next = 1'b1;
                out_row_next   = row_reg;
                out_sum_next   = '0;
                out_sat_next   = 1'b0;
                row_next       = row_adv;
            end else if (item.last) begin
                out_valid_next = 1'b1;
                out_row_next   = row_reg;
                out_sum_next   = acc_add;
                out_sat_next   = clip_add;
                acc_next       = '0;
                clip_next      = 1'b0;
                row_next       = row_adv;
            end else begin
                acc_next  = acc_add;
                clip_next = clip_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            clip_reg      <= clip_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_row_reg <= out_row_next;
        out_sum_reg <= out_sum_next;
        out_sat_reg <= out_sat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_sum   = out_sum_reg;
    assign out_sat   = out_sat_reg;

endmodule

`default_nettype wire

// File: sv/csrspmv_chk.sv
`default_nettype none

`include "csr_sparse_matrix_vector_multiply_macros.svh"

module csrspmv_chk (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [csrspmv_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                                m_tuser
);

    // a stalled result keeps its valid and payload
    `CSRSPMV_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // with no result waiting every stage can move, so input is taken
    `CSRSPMV_ASSERT(a_ready_when_out_empty, !m_tvalid |-> s_tready, "input blocked with result register empty")

    // reset drops any pending result
    `CSRSPMV_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind csr_sparse_matrix_vector_multiply csrspmv_chk u_chk (.*);

`default_nettype wire
